/* hw/rtl/lsp2c_pkg.sv */
// shared types, constants and the sine table builder for the scan converter
`default_nettype none

package lsp2c_pkg;

  localparam int QUARTER_TABLE_BITS = 8;
  localparam int RANGE_BITS         = 20;

  localparam int QSIZE       = 1 << QUARTER_TABLE_BITS;
  localparam int IDX_W       = QUARTER_TABLE_BITS + 1;
  localparam int OUT_BITS    = RANGE_BITS + 1;
  localparam int TRIG_W      = 15;
  localparam int PROD_W      = RANGE_BITS + TRIG_W;
  localparam int IN_TDATA_W  = ((RANGE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * OUT_BITS + 7) / 8) * 8;
  localparam int ANGLE_W     = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 4;

  localparam logic [RANGE_BITS:0]   RANGE_MARGIN  = (RANGE_BITS + 1)'(102);
  localparam logic [RANGE_BITS-1:0] MAX_RANGE_RST = RANGE_BITS'(32'd1048575);
  localparam logic [ANGLE_W-1:0]    START_RST     = 16'h8000;
  localparam logic [ANGLE_W-1:0]    STEP_RST      = 16'd64;
  localparam logic [ANGLE_W-1:0]    QUARTER_TURN  = 16'h4000;
  localparam logic [PROD_W:0]       ROUND_NEG     = (PROD_W + 1)'(32767);

  localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
  localparam logic [63:0] ONE_Q31     = 64'd2147483648;

  typedef enum logic [1:0] {
    REG_MIN_RANGE   = 2'd0,
    REG_MAX_RANGE   = 2'd1,
    REG_START_ANGLE = 2'd2,
    REG_ANGLE_STEP  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0] min_range;
    logic [RANGE_BITS-1:0] max_range;
    logic [ANGLE_W-1:0]    start_angle;
    logic [ANGLE_W-1:0]    angle_step;
  } cfg_t;

  // one accepted sample after lookup: range and signed trig magnitudes
  typedef struct packed {
    logic [RANGE_BITS-1:0] range;
    logic [TRIG_W-1:0]     cos_mag;
    logic                  cos_neg;
    logic [TRIG_W-1:0]     sin_mag;
    logic                  sin_neg;
  } trig_t;

  // quarter-wave entry, q31 taylor series up to x^15, evaluated at elaboration
  function automatic logic [TRIG_W-1:0] sine_entry(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sub;
    logic [63:0] s;
    logic [63:0] v;
    x   = (HALF_PI_Q31 * 64'(i)) >> QUARTER_TABLE_BITS;
    x2  = (x * x) >> 31;
    t   = ONE_Q31;
    sub = ((x2 * t) >> 31) / 64'd210;
    t   = (sub >= ONE_Q31) ? 64'd0 : ONE_Q31 - sub;
    sub = ((x2 * t) >> 31) / 64'd156;
    t   = (sub >= ONE_Q31) ? 64'd0 : ONE_Q31 - sub;
    sub = ((x2 * t) >> 31) / 64'd110;
    t   = (sub >= ONE_Q31) ? 64'd0 : ONE_Q31 - sub;
    sub = ((x2 * t) >> 31) / 64'd72;
    t   = (sub >= ONE_Q31) ? 64'd0 : ONE_Q31 - sub;
    sub = ((x2 * t) >> 31) / 64'd42;
    t   = (sub >= ONE_Q31) ? 64'd0 : ONE_Q31 - sub;
    sub = ((x2 * t) >> 31) / 64'd20;
    t   = (sub >= ONE_Q31) ? 64'd0 : ONE_Q31 - sub;
    sub = ((x2 * t) >> 31) / 64'd6;
    t   = (sub >= ONE_Q31) ? 64'd0 : ONE_Q31 - sub;
    s   = (x * t) >> 31;
    v   = (64'd32767 * s + (64'd1 << 30)) >> 31;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[TRIG_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/lidar_scan_polar_to_cartesian.sv */
// Lidar scan polar-to-cartesian converter, top level.
// Input stream: one range sample per word, in_tdata[19:0] in 1/1024 m, in_tuser marks
// the first sample of a scan (angle restarts at start_angle). Every other sample
// takes the previous angle plus angle_step, wrapping over a full 16-bit turn.
// A sample inside (min_range, max_range - 102) gives one output word with
// x = range*cos and y = range*sin; any other sample gives no word at all.
// Output stream: out_tdata[20:0] is x, out_tdata[41:21] is y, both signed.
// An accepted sample passes the lookup, multiply and round/sign stage registers in
// turn before out_tvalid. Throughput is one sample per cycle while the receiver
// does not stall, set by the three-stage pipeline with one word held in each stage.
// When the receiver stalls, the stages fill up one by one; in_tready drops only
// when all three hold a word, so the lookup stage still takes samples that
// fall outside the range window.
// The user must write the registers over the apb port only while the stream is
// idle; the block does not enforce it. Reset clears the pipeline valids, sets the
// registers to their defaults and the running angle to zero.
`default_nettype none

module lidar_scan_polar_to_cartesian
  import lsp2c_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // fields from bit 0: range_sample
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // fields from bit 0: first_of_scan
  input  logic                   in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // fields from bit 0: point_x, point_y
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t                cfg;
  trig_t               trig;
  logic                trig_valid;
  logic                trig_ready;
  logic [OUT_BITS-1:0] out_x;
  logic [OUT_BITS-1:0] out_y;

  lsp2c_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lsp2c_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_range   (in_tdata[RANGE_BITS-1:0]),
    .in_first   (in_tuser),
    .nxt_ready  (trig_ready),
    .trig_valid (trig_valid),
    .trig       (trig)
  );

  lsp2c_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .trig_valid (trig_valid),
    .trig       (trig),
    .trig_ready (trig_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_x      (out_x),
    .out_y      (out_y)
  );

  assign out_tdata = OUT_TDATA_W'({out_y, out_x});

endmodule

`default_nettype wire

/* hw/rtl/lsp2c_cfg.sv */
// apb register file: range limits, start angle and angle step
`default_nettype none

module lsp2c_cfg
  import lsp2c_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_range   <= '0;
      cfg_r.max_range   <= MAX_RANGE_RST;
      cfg_r.start_angle <= START_RST;
      cfg_r.angle_step  <= STEP_RST;
    end else if (wr_en) begin
      case (idx)
        REG_MIN_RANGE:   cfg_r.min_range   <= cfg_pwdata[RANGE_BITS-1:0];
        REG_MAX_RANGE:   cfg_r.max_range   <= cfg_pwdata[RANGE_BITS-1:0];
        REG_START_ANGLE: cfg_r.start_angle <= cfg_pwdata[ANGLE_W-1:0];
        REG_ANGLE_STEP:  cfg_r.angle_step  <= cfg_pwdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_RANGE:   cfg_prdata = CFG_DATA_W'(cfg_r.min_range);
      REG_MAX_RANGE:   cfg_prdata = CFG_DATA_W'(cfg_r.max_range);
      REG_START_ANGLE: cfg_prdata = CFG_DATA_W'(cfg_r.start_angle);
      REG_ANGLE_STEP:  cfg_prdata = CFG_DATA_W'(cfg_r.angle_step);
      default:         cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/lsp2c_front.sv */
// first stage: beam angle tracking, range gate and sine/cosine table lookup
`default_nettype none

module lsp2c_front
  import lsp2c_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [RANGE_BITS-1:0] in_range,
  input  logic                  in_first,
  input  logic                  nxt_ready,
  output logic                  trig_valid,
  output trig_t                 trig
);

  logic [TRIG_W-1:0]  tab [0:QSIZE];
  logic [ANGLE_W-1:0] next_angle_r;
  logic [ANGLE_W-1:0] next_angle_nxt;
  logic [ANGLE_W-1:0] angle;
  logic [ANGLE_W-1:0] angle_c;
  logic [IDX_W-1:0]   idx_s;
  logic [IDX_W-1:0]   idx_c;
  logic [RANGE_BITS:0] range_pad;
  logic               in_gate;
  logic               accept;
  logic               valid_r;
  logic               valid_nxt;
  trig_t              trig_r;
  trig_t              trig_nxt;

  for (genvar g = 0; g <= QSIZE; g++) begin : g_tab
    localparam logic [TRIG_W-1:0] ENTRY = sine_entry(g);
    assign tab[g] = ENTRY;
  end

  assign in_tready = !valid_r | nxt_ready;
  assign accept    = in_tvalid & in_tready;

  assign angle          = in_first ? cfg.start_angle : next_angle_r;
  assign angle_c        = angle + QUARTER_TURN;
  assign next_angle_nxt = angle + cfg.angle_step;

  // range + margin < max covers a max below the margin as well
  assign range_pad = {1'b0, in_range} + RANGE_MARGIN;
  assign in_gate   = (in_range > cfg.min_range) && (range_pad < {1'b0, cfg.max_range});

  // odd quadrants read the quarter table mirrored
  always_comb begin
    idx_s = {1'b0, angle[13 -: QUARTER_TABLE_BITS]};
    idx_c = {1'b0, angle_c[13 -: QUARTER_TABLE_BITS]};
    if (angle[14]) begin
      idx_s = IDX_W'(QSIZE) - idx_s;
    end
    if (angle_c[14]) begin
      idx_c = IDX_W'(QSIZE) - idx_c;
    end
  end

  always_comb begin
    trig_nxt.range   = in_range;
    trig_nxt.sin_mag = tab[idx_s];
    trig_nxt.sin_neg = angle[15];
    trig_nxt.cos_mag = tab[idx_c];
    trig_nxt.cos_neg = angle_c[15];
    valid_nxt        = valid_r & !nxt_ready;
    if (accept) begin
      valid_nxt = in_gate;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_angle_r <= '0;
      valid_r      <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (accept) begin
        next_angle_r <= next_angle_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      trig_r <= trig_nxt;
    end
  end

  assign trig_valid = valid_r;
  assign trig       = trig_r;

endmodule

`default_nettype wire

/* hw/rtl/lsp2c_scale.sv */
// multiply stage and rounding/sign stage, ending in the output register
`default_nettype none

module lsp2c_scale
  import lsp2c_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                trig_valid,
  input  trig_t               trig,
  output logic                trig_ready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_BITS-1:0] out_x,
  output logic [OUT_BITS-1:0] out_y
);

  logic                prod_valid_r;
  logic [PROD_W-1:0]   prod_x_r;
  logic [PROD_W-1:0]   prod_y_r;
  logic                neg_x_r;
  logic                neg_y_r;
  logic                out_valid_r;
  logic [OUT_BITS-1:0] out_x_r;
  logic [OUT_BITS-1:0] out_y_r;
  logic [OUT_BITS-1:0] out_x_nxt;
  logic [OUT_BITS-1:0] out_y_nxt;
  logic [PROD_W:0]     sum_x;
  logic [PROD_W:0]     sum_y;
  logic                out_adv;
  logic                prod_adv;

  assign out_adv    = !out_valid_r | out_tready;
  assign prod_adv   = !prod_valid_r | out_adv;
  assign trig_ready = prod_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (prod_adv) begin
        prod_valid_r <= trig_valid;
      end
      if (out_adv) begin
        out_valid_r <= prod_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_adv && trig_valid) begin
      prod_x_r <= PROD_W'(trig.range) * PROD_W'(trig.cos_mag);
      prod_y_r <= PROD_W'(trig.range) * PROD_W'(trig.sin_mag);
      neg_x_r  <= trig.cos_neg;
      neg_y_r  <= trig.sin_neg;
    end
  end

  // negative side rounds the magnitude up so the shift floors toward minus infinity
  always_comb begin
    sum_x = {1'b0, prod_x_r} + (neg_x_r ? ROUND_NEG : '0);
    sum_y = {1'b0, prod_y_r} + (neg_y_r ? ROUND_NEG : '0);
    out_x_nxt = sum_x[PROD_W:TRIG_W];
    out_y_nxt = sum_y[PROD_W:TRIG_W];
    if (neg_x_r) begin
      out_x_nxt = -out_x_nxt;
    end
    if (neg_y_r) begin
      out_y_nxt = -out_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && prod_valid_r) begin
      out_x_r <= out_x_nxt;
      out_y_r <= out_y_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;

endmodule

`default_nettype wire

/* hw/rtl/lsp2c_chk.sv */
// port-level checker for the scan converter, bound to the top level
`default_nettype none

module lsp2c_chk
  import lsp2c_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready
);

  localparam logic [OUT_BITS-1:0] MOST_NEG = {1'b1, {(OUT_BITS - 1){1'b0}}};

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // with every stage full and stalled, no new sample may be taken
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && !in_tready |=> !in_tready || out_tready)
    else $error("input ready rose while output still stalled");

  // products never reach the most negative code
  a_out_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_BITS-1:0] != MOST_NEG) &&
                   (out_tdata[2*OUT_BITS-1:OUT_BITS] != MOST_NEG))
    else $error("coordinate out of range");

endmodule

bind lidar_scan_polar_to_cartesian lsp2c_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
